// ===== hdl/sobel3_pkg.sv =====
// Shared types and fixed field widths for the 3x3 Sobel convolution block.
`timescale 1ns / 1ps

package sobel3_pkg;

    // Widths fixed by the port definition of the block.
    localparam int CFG_W    = 11;
    localparam int PIX_IN_W = 8;
    localparam int RES_W    = 11;
    localparam int POS_W    = 11;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

// ===== hdl/sobel_full_convolution_3x3.sv =====
// Streaming full 3x3 Sobel (horizontal gradient) convolution with zero padding.
// A pixel accepted on s_* is held in the working stage; its results pass through the result register to m_*.
// Throughput: one pixel per cycle when each pixel yields one result and m_ready holds no
// result back; a pixel at the end of a row or in the last row yields 3 results and the final
// pixel of a frame 9, one per cycle unless m_ready stalls, via the single result register.
// Reset (aresetn low, synchronous): frame size returns to 4x4, position counters, window and
// valid flags clear; line buffer contents are undefined until written.
`timescale 1ns / 1ps

module sobel_full_convolution_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_wr_en,
    input  sobel3_pkg::cfg_reg_t                 cfg_index,
    input  logic [sobel3_pkg::CFG_W-1:0]         cfg_wr_data,
    // Pixel input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [sobel3_pkg::PIX_IN_W-1:0]      s_pixel,
    // Result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sobel3_pkg::RES_W-1:0]  m_result_value,
    output logic [sobel3_pkg::POS_W-1:0]         m_out_row,
    output logic [sobel3_pkg::POS_W-1:0]         m_out_col,
    output logic                                 m_last_in_run,
    output logic                                 m_end_of_frame
);

    import sobel3_pkg::*;

    // Column and row index widths, and a width that holds any frame size for compares.
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int XYW   = (XW > YW) ? XW : YW;
    localparam int SZ_W  = (CFG_W > XYW + 1) ? CFG_W : XYW + 1;
    localparam int PW    = PIXEL_BITS;
    // The sum of four pixel differences needs PW+2 bits plus sign.
    localparam int SUM_W = (RES_W > PW + 4) ? RES_W : PW + 4;

    // ------------------------------------------------------------------
    // Configuration registers and the effective (clamped) frame size.
    // A size of zero acts as one; a size above the maximum saturates.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [XW-1:0]    w_last;
    logic [YW-1:0]    h_last;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_last = '0;
        end else if (SZ_W'(frame_width_reg) > SZ_W'(MAX_WIDTH)) begin
            w_last = XW'(MAX_WIDTH - 1);
        end else begin
            w_last = XW'(SZ_W'(frame_width_reg) - SZ_W'(1));
        end
        if (frame_height_reg == '0) begin
            h_last = '0;
        end else if (SZ_W'(frame_height_reg) > SZ_W'(MAX_HEIGHT)) begin
            h_last = YW'(MAX_HEIGHT - 1);
        end else begin
            h_last = YW'(SZ_W'(frame_height_reg) - SZ_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Position counters. They are resolved at input acceptance: a counter
    // beyond the current last column or row is treated as being on it.
    // ------------------------------------------------------------------
    logic [XW-1:0] col_count_reg;
    logic [YW-1:0] row_count_reg;
    logic [XW-1:0] c_cur;
    logic [YW-1:0] r_cur;
    logic          c_is_last;
    logic          r_is_last;
    logic [XW-1:0] col_count_next;
    logic [YW-1:0] row_count_next;

    always_comb begin
        c_cur     = (col_count_reg > w_last) ? w_last : col_count_reg;
        r_cur     = (row_count_reg > h_last) ? h_last : row_count_reg;
        c_is_last = (c_cur == w_last);
        r_is_last = (r_cur == h_last);
        if (c_is_last) begin
            col_count_next = '0;
            row_count_next = r_is_last ? '0 : r_cur + 1'b1;
        end else begin
            col_count_next = c_cur + 1'b1;
            row_count_next = r_cur;
        end
    end

    // ------------------------------------------------------------------
    // Handshake control. The working stage holds one pixel while its
    // results are walked out; it frees up in the same cycle that its
    // last result enters the output register, so a new transaction can
    // be taken in every cycle for single-result pixels while m_ready keeps up.
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic [1:0]    dt_reg;
    logic [1:0]    di_reg;
    logic          s1_last_row_reg;
    logic          s1_last_col_reg;
    logic          m_valid_reg;
    logic          out_free;
    logic          emit;
    logic          is_last;
    logic          retire;
    logic          accept;
    logic [1:0]    dt_last;
    logic [1:0]    di_last;

    assign dt_last  = s1_last_row_reg ? 2'd2 : 2'd0;
    assign di_last  = s1_last_col_reg ? 2'd2 : 2'd0;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = s1_valid_reg && out_free;
    assign is_last  = (dt_reg == dt_last) && (di_reg == di_last);
    assign retire   = emit && is_last;
    assign s_ready  = !s1_valid_reg || retire;
    assign accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Working stage payload: pixel, position and padding flags.
    // ------------------------------------------------------------------
    logic [PW-1:0] s1_pix_reg;
    logic [YW-1:0] s1_row_reg;
    logic [XW-1:0] s1_col_reg;
    logic          s1_r_ge1_reg;
    logic          s1_r_ge2_reg;
    logic          s1_c_ge1_reg;
    logic          s1_c_ge2_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg      <= PW'(s_pixel);
            s1_row_reg      <= r_cur;
            s1_col_reg      <= c_cur;
            s1_last_row_reg <= r_is_last;
            s1_last_col_reg <= c_is_last;
            s1_r_ge1_reg    <= (r_cur != '0);
            s1_r_ge2_reg    <= (r_cur > YW'(1));
            s1_c_ge1_reg    <= (c_cur != '0);
            s1_c_ge2_reg    <= (c_cur > XW'(1));
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: one word per column holds {row two above, row above}.
    // It is read at acceptance and rewritten when the pixel retires. When
    // a retiring pixel writes the column that the new pixel reads (a one
    // pixel wide frame), the written word is forwarded instead.
    // ------------------------------------------------------------------
    logic [2*PW-1:0] line_mem [MAX_WIDTH];
    logic [2*PW-1:0] line_rd_reg;
    logic            fwd_hit_reg;
    logic [2*PW-1:0] fwd_data_reg;
    logic [2*PW-1:0] line_word;
    logic [2*PW-1:0] line_wr_data;
    logic [PW-1:0]   above_raw;
    logic [PW-1:0]   two_above_raw;

    assign line_word     = fwd_hit_reg ? fwd_data_reg : line_rd_reg;
    assign above_raw     = line_word[PW-1:0];
    assign two_above_raw = line_word[2*PW-1:PW];
    assign line_wr_data  = {above_raw, s1_pix_reg};

    always_ff @(posedge aclk) begin
        if (retire) begin
            line_mem[s1_col_reg] <= line_wr_data;
        end
        if (accept) begin
            line_rd_reg  <= line_mem[c_cur];
            fwd_hit_reg  <= retire && (s1_col_reg == c_cur);
            fwd_data_reg <= line_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // 3x3 neighborhood. Column 2 is the current column (line buffer and
    // the new pixel), columns 0 and 1 come from the two-column window.
    // Rows above row 0 and columns left of column 0 read as zero.
    // ------------------------------------------------------------------
    logic [PW-1:0]           win0_reg [3];
    logic [PW-1:0]           win1_reg [3];
    logic [PW-1:0]           new_col  [3];
    logic [2:0]              row_ok;
    logic signed [SUM_W-1:0] pv0 [3];
    logic signed [SUM_W-1:0] pv1 [3];
    logic signed [SUM_W-1:0] pv2 [3];
    logic signed [SUM_W-1:0] diff [3];

    always_comb begin
        new_col[0] = s1_r_ge2_reg ? two_above_raw : '0;
        new_col[1] = s1_r_ge1_reg ? above_raw : '0;
        new_col[2] = s1_pix_reg;
        row_ok     = {1'b1, s1_r_ge1_reg, s1_r_ge2_reg};
        for (int i = 0; i < 3; i++) begin
            pv0[i] = (row_ok[i] && s1_c_ge2_reg) ? SUM_W'(win1_reg[i]) : '0;
            pv1[i] = (row_ok[i] && s1_c_ge1_reg) ? SUM_W'(win0_reg[i]) : '0;
            pv2[i] = SUM_W'(new_col[i]);
            // Horizontal difference for output column offset di.
            case (di_reg)
                2'd0:    diff[i] = pv2[i] - pv0[i];
                2'd1:    diff[i] = -pv1[i];
                default: diff[i] = -pv2[i];
            endcase
        end
    end

    // Vertical weighting for output row offset dt: rows dt..2 carry
    // weights 1,2,1 starting from the top of the kernel.
    logic signed [SUM_W-1:0] term_a;
    logic signed [SUM_W-1:0] term_b;
    logic signed [SUM_W-1:0] term_c;
    logic signed [SUM_W-1:0] conv_sum;

    always_comb begin
        case (dt_reg)
            2'd0: begin
                term_a = diff[0];
                term_b = diff[1];
                term_c = diff[2];
            end
            2'd1: begin
                term_a = diff[1];
                term_b = diff[2];
                term_c = '0;
            end
            default: begin
                term_a = diff[2];
                term_b = '0;
                term_c = '0;
            end
        endcase
        conv_sum = term_a + (term_b <<< 1) + term_c;
    end

    // ------------------------------------------------------------------
    // Control registers: configuration, counters, window, stage valids
    // and the result sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= CFG_W'(4);
            frame_height_reg <= CFG_W'(4);
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            dt_reg           <= 2'd0;
            di_reg           <= 2'd0;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                win0_reg[i] <= '0;
                win1_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                    default: ;
                endcase
            end

            if (accept) begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end

            // The window shifts by one column when a pixel retires.
            if (retire) begin
                for (int i = 0; i < 3; i++) begin
                    win1_reg[i] <= win0_reg[i];
                    win0_reg[i] <= new_col[i];
                end
            end

            if (accept) begin
                s1_valid_reg <= 1'b1;
                dt_reg       <= 2'd0;
                di_reg       <= 2'd0;
            end else if (retire) begin
                s1_valid_reg <= 1'b0;
                dt_reg       <= 2'd0;
                di_reg       <= 2'd0;
            end else if (emit) begin
                if (di_reg == di_last) begin
                    di_reg <= 2'd0;
                    dt_reg <= dt_reg + 2'd1;
                end else begin
                    di_reg <= di_reg + 2'd1;
                end
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register payload.
    // ------------------------------------------------------------------
    logic signed [RES_W-1:0] m_result_value_reg;
    logic [POS_W-1:0]        m_out_row_reg;
    logic [POS_W-1:0]        m_out_col_reg;
    logic                    m_last_in_run_reg;
    logic                    m_end_of_frame_reg;

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_result_value_reg <= conv_sum[RES_W-1:0];
            m_out_row_reg      <= POS_W'(SZ_W'(s1_row_reg) + SZ_W'(dt_reg));
            m_out_col_reg      <= POS_W'(SZ_W'(s1_col_reg) + SZ_W'(di_reg));
            m_last_in_run_reg  <= is_last;
            m_end_of_frame_reg <= s1_last_row_reg && s1_last_col_reg
                                  && (dt_reg == 2'd2) && (di_reg == 2'd2);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_out_row      = m_out_row_reg;
    assign m_out_col      = m_out_col_reg;
    assign m_last_in_run  = m_last_in_run_reg;
    assign m_end_of_frame = m_end_of_frame_reg;

`ifndef SYNTHESIS
    // The frame corner result is always the final one of its pixel.
    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_frame) |-> m_last_in_run)
        else $error("end_of_frame on a result that is not last_in_run");

    // An accepted pixel occupies the working stage in the next cycle.
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted pixel did not reach the working stage");

    // The sequencer never steps past the third row or column offset.
    a_seq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> ((dt_reg != 2'd3) && (di_reg != 2'd3)))
        else $error("result sequencer out of range");

    // Only a pixel in the last row produces extra output rows.
    a_seq_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_last_row_reg) |-> (dt_reg == 2'd0))
        else $error("extra output row for a pixel not in the last row");
`endif

endmodule
